### rtl/qrsa_pkg.sv
// Package with the shared types and constants of the quad-to-rectangle address generator.
`timescale 1ns / 1ps
`default_nettype none
package qrsa_pkg;

	// Coordinate width and its largest value.
	localparam int CW        = 12;
	localparam int COORD_MAX = (1 << CW) - 1;
	// Width of a product of a coordinate difference and an index.
	localparam int PW        = 2 * CW;
	// Number of configuration registers and the width of their index.
	localparam int NUM_REGS  = 8;
	localparam int RIW       = $clog2(NUM_REGS);

	typedef logic [CW-1:0] coord_t;

	// Register indexes of the configuration port.
	typedef enum logic [RIW-1:0] {
		REG_TOP_LEFT_X     = 3'd0,
		REG_TOP_LEFT_Y     = 3'd1,
		REG_BOTTOM_LEFT_X  = 3'd2,
		REG_BOTTOM_LEFT_Y  = 3'd3,
		REG_TOP_RIGHT_X    = 3'd4,
		REG_TOP_RIGHT_Y    = 3'd5,
		REG_BOTTOM_RIGHT_X = 3'd6,
		REG_BOTTOM_RIGHT_Y = 3'd7
	} reg_idx_t;

	// Input word: one output pixel position.
	typedef struct packed {
		coord_t out_col;
		coord_t out_row;
	} in_t;

	// Output word: source address and derived output size.
	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		logic   in_range;
		coord_t out_width;
		coord_t out_height;
	} out_t;

endpackage
`default_nettype wire

### rtl/quad_to_rect_source_address.sv
// Top level of the quad-to-rectangle source address generator.
//
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+--------------------------------
// in      | input     | in_valid/in_ready  | in_t: out_col, out_row
// out     | output    | out_valid/out_ready| out_t: src_x, src_y, in_range, size
// cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high; the path runs through
// two interpolators of 14 stages each (product, twelve restoring divide stages,
// floor and add) and the output register. The divide stages set the depth.
// Reset clears the corners to their defaults and empties the pipeline.
// A stalled output parks one more word in a skid register before in_ready
// drops, so nothing is lost or repeated. Width and height are registered from
// the corners, so they follow a corner write through their own register.
`timescale 1ns / 1ps
`default_nettype none
module quad_to_rect_source_address
	import qrsa_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire in_t            in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output out_t                out_data,
	input  wire logic           cfg_wr_en,
	input  wire logic [RIW-1:0] cfg_index,
	input  wire logic [CW-1:0]  cfg_data
);

	coord_t tlx, tly, blx, bly, trx, try_, brx, bry, width, height;

	qrsa_cfg u_cfg (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.tlx, .tly, .blx, .bly, .trx, .try_, .brx, .bry, .width, .height
	);

	logic en;
	logic in_range;
	coord_t s1_start [4];
	coord_t s1_stop  [4];
	coord_t s1_res   [4];
	logic   s1_valid;
	logic [CW:0] s1_side;

	// Range check at entry; it travels with the word.
	assign in_range = (in_data.out_col < width) && (in_data.out_row < height);
	assign s1_start = '{tlx, tly, blx, bly};
	assign s1_stop  = '{trx, try_, brx, bry};

	// Points on the top and bottom edges.
	qrsa_lerp #(.LANES(4), .SIDE_W(CW + 1)) u_edge (
		.clk, .arst_n, .en,
		.in_valid (in_valid && en),
		.start    (s1_start),
		.stop     (s1_stop),
		.idx      (in_data.out_col),
		.size     (width),
		.side_in  ({in_data.out_row, in_range}),
		.out_valid(s1_valid),
		.result   (s1_res),
		.side_out (s1_side)
	);

	coord_t s2_start [2];
	coord_t s2_stop  [2];
	coord_t s2_res   [2];
	logic   s2_valid;
	logic   s2_inr;

	assign s2_start = '{s1_res[0], s1_res[1]};
	assign s2_stop  = '{s1_res[2], s1_res[3]};

	// Point between the top and bottom edge points.
	qrsa_lerp #(.LANES(2), .SIDE_W(1)) u_vert (
		.clk, .arst_n, .en,
		.in_valid (s1_valid),
		.start    (s2_start),
		.stop     (s2_stop),
		.idx      (s1_side[CW:1]),
		.size     (height),
		.side_in  (s1_side[0]),
		.out_valid(s2_valid),
		.result   (s2_res),
		.side_out (s2_inr)
	);

	out_t last;
	out_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic take;

	// Finished word; source fields are zero outside the output.
	always_comb begin
		last.src_x      = s2_inr ? s2_res[0] : '0;
		last.src_y      = s2_inr ? s2_res[1] : '0;
		last.in_range   = s2_inr;
		last.out_width  = width;
		last.out_height = height;
	end

	assign en   = !skid_valid_q;
	assign take = s2_valid && en;

	// Output register with one skid word behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (take) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (take) begin
				skid_q <= last;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (take) begin
			out_q <= last;
		end
	end

	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### rtl/qrsa_cfg.sv
// Corner registers and the derived output width and height.
`timescale 1ns / 1ps
`default_nettype none
module qrsa_cfg
	import qrsa_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [RIW-1:0] cfg_index,
	input  wire logic [CW-1:0]  cfg_data,
	output coord_t              tlx,
	output coord_t              tly,
	output coord_t              blx,
	output coord_t              bly,
	output coord_t              trx,
	output coord_t              try_,
	output coord_t              brx,
	output coord_t              bry,
	output coord_t              width,
	output coord_t              height
);

	coord_t tlx_q, tly_q, blx_q, bly_q, trx_q, try_q, brx_q, bry_q;
	coord_t width_q, height_q;
	logic [CW:0] wdiff, hdiff;
	coord_t lo_x, hi_x, lo_y, hi_y;

	// Register writes; every index in the list is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlx_q <= '0;
			tly_q <= '0;
			blx_q <= '0;
			bly_q <= coord_t'(COORD_MAX);
			trx_q <= coord_t'(COORD_MAX);
			try_q <= '0;
			brx_q <= coord_t'(COORD_MAX);
			bry_q <= coord_t'(COORD_MAX);
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_TOP_LEFT_X:     tlx_q <= cfg_data;
				REG_TOP_LEFT_Y:     tly_q <= cfg_data;
				REG_BOTTOM_LEFT_X:  blx_q <= cfg_data;
				REG_BOTTOM_LEFT_Y:  bly_q <= cfg_data;
				REG_TOP_RIGHT_X:    trx_q <= cfg_data;
				REG_TOP_RIGHT_Y:    try_q <= cfg_data;
				REG_BOTTOM_RIGHT_X: brx_q <= cfg_data;
				REG_BOTTOM_RIGHT_Y: bry_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Extents of the quadrilateral; a crossed pair gives zero.
	always_comb begin
		lo_x  = (tlx_q < blx_q) ? tlx_q : blx_q;
		hi_x  = (trx_q > brx_q) ? trx_q : brx_q;
		lo_y  = (tly_q < try_q) ? tly_q : try_q;
		hi_y  = (bly_q > bry_q) ? bly_q : bry_q;
		wdiff = {1'b0, hi_x} - {1'b0, lo_x};
		hdiff = {1'b0, hi_y} - {1'b0, lo_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else begin
			width_q  <= wdiff[CW] ? '0 : wdiff[CW-1:0];
			height_q <= hdiff[CW] ? '0 : hdiff[CW-1:0];
		end
	end

	assign tlx    = tlx_q;
	assign tly    = tly_q;
	assign blx    = blx_q;
	assign bly    = bly_q;
	assign trx    = trx_q;
	assign try_   = try_q;
	assign brx    = brx_q;
	assign bry    = bry_q;
	assign width  = width_q;
	assign height = height_q;

endmodule
`default_nettype wire

### rtl/qrsa_lerp.sv
// Pipelined interpolator: start + floor((stop - start) * idx / size) on several lanes.
`timescale 1ns / 1ps
`default_nettype none
module qrsa_lerp
	import qrsa_pkg::*;
#(
	parameter int LANES  = 4,
	parameter int SIDE_W = 1
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire coord_t            start [LANES],
	input  wire coord_t            stop  [LANES],
	input  wire coord_t            idx,
	input  wire coord_t            size,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output coord_t                 result [LANES],
	output logic [SIDE_W-1:0]      side_out
);

	// One divide stage per quotient bit.
	localparam int NS = CW;

	logic [PW-1:0]     prod   [LANES];
	logic              neg    [LANES];
	logic [CW:0]       delta  [LANES];
	coord_t            mag    [LANES];

	logic              v_d    [NS+1];
	logic [PW-1:0]     rem_d  [NS+1][LANES];
	coord_t            q_d    [NS+1][LANES];
	logic              neg_d  [NS+1][LANES];
	coord_t            start_d[NS+1][LANES];
	coord_t            size_d [NS+1];
	logic [SIDE_W-1:0] side_d [NS+1];

	logic              v_q;
	coord_t            res_q  [LANES];
	logic [SIDE_W-1:0] side_q;

	// First stage: magnitude of the difference times the index.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			delta[l] = {1'b0, stop[l]} - {1'b0, start[l]};
			neg[l]   = delta[l][CW];
			mag[l]   = neg[l] ? coord_t'(-delta[l]) : delta[l][CW-1:0];
			prod[l]  = PW'(mag[l]) * PW'(idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (en) begin
			v_d[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				rem_d[0][l]   <= prod[l];
				q_d[0][l]     <= '0;
				neg_d[0][l]   <= neg[l];
				start_d[0][l] <= start[l];
			end
			size_d[0] <= size;
			side_d[0] <= side_in;
		end
	end

	// Restoring divide, one quotient bit per stage, most significant first.
	for (genvar k = 0; k < NS; k++) begin : g_div
		localparam int B = NS - 1 - k;
		logic [PW:0]   dvs;
		logic [PW:0]   diff [LANES];

		always_comb begin
			dvs = (PW+1)'(size_d[k]) << B;
			for (int l = 0; l < LANES; l++) begin
				diff[l] = {1'b0, rem_d[k][l]} - dvs;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (en) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					if (!diff[l][PW]) begin
						rem_d[k+1][l] <= diff[l][PW-1:0];
						q_d[k+1][l]   <= q_d[k][l] | (coord_t'(1) << B);
					end else begin
						rem_d[k+1][l] <= rem_d[k][l];
						q_d[k+1][l]   <= q_d[k][l];
					end
					neg_d[k+1][l]   <= neg_d[k][l];
					start_d[k+1][l] <= start_d[k][l];
				end
				size_d[k+1] <= size_d[k];
				side_d[k+1] <= side_d[k];
			end
		end
	end

	// Last stage: floor for a negative difference, then add the start point.
	logic [CW:0]   qq  [LANES];
	logic [CW+1:0] off [LANES];
	logic [CW+1:0] sum [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qq[l]  = {1'b0, q_d[NS][l]} + (CW+1)'(rem_d[NS][l] != '0);
			off[l] = neg_d[NS][l] ? -{1'b0, qq[l]} : {2'b00, q_d[NS][l]};
			sum[l] = {2'b00, start_d[NS][l]} + off[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_d[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				res_q[l] <= sum[l][CW-1:0];
			end
			side_q <= side_d[NS];
		end
	end

	assign out_valid = v_q;
	assign result    = res_q;
	assign side_out  = side_q;

endmodule
`default_nettype wire

### rtl/qrsa_chk.sv
// Port checker for the quad-to-rectangle source address generator, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module qrsa_chk
	import qrsa_pkg::*;
(
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire in_t            in_data,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire out_t           out_data
);

	// A waiting input word holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// A pixel outside the output reads source zero.
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_range |-> out_data.src_x == '0 && out_data.src_y == '0)
		else $error("source address not zero outside the output");

	// A pixel in range implies a non-empty output.
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_range |->
		out_data.out_width != '0 && out_data.out_height != '0)
		else $error("pixel in range of an empty output");

	// Nothing is delivered straight after reset.
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind quad_to_rect_source_address qrsa_chk u_qrsa_chk (.*);
`default_nettype wire
